FILE: sv/ffla_pkg.sv
// ffla_pkg: shared types and constants of the first-fit free-list allocator.
// Holds the item structs, status and operation codes and the sequencer states.
// No dependencies.
package ffla_pkg;

   // Default geometry (byte heap, alignment and header size are powers of two)
   localparam int HEAP_BYTES_DEF   = 4096;
   localparam int ALIGN_BYTES_DEF  = 8;
   localparam int HEADER_BYTES_DEF = 16;

   // Heap size register
   localparam int CSR_W = 12;
   localparam logic [CSR_W-1:0] INIT_HEAP_SIZE = CSR_W'(1000);

   // Field widths
   localparam int SIZE_W = 12;
   localparam int ADDR_W = 12;

   typedef enum logic {
      FUNC_ALLOC = 1'b0,
      FUNC_FREE  = 1'b1
   } func_type;

   typedef enum logic [2:0] {
      STAT_ALLOCATED = 3'd0,
      STAT_SIZE_ZERO = 3'd1,
      STAT_NO_FIT    = 3'd2,
      STAT_FREED     = 3'd3,
      STAT_NULL_FREE = 3'd4
   } status_type;

   typedef struct packed {
      func_type          func;
      logic [SIZE_W-1:0] request_size;
      logic [ADDR_W-1:0] data_address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] alloc_address;
      status_type        status;
   } rsp_type;

   // Verdict of the fit unit on one header
   typedef struct packed {
      logic fits;
      logic split;
   } fit_flags_type;

   typedef enum logic [1:0] {
      ST_INIT,
      ST_IDLE,
      ST_WALK,
      ST_FIX
   } state_type;

endpackage

FILE: sv/ffla_hdr_ram.sv
// ffla_hdr_ram: one header field store, one write port and one registered read port.
// Used for the block size store and the next link store. No dependencies.
module ffla_hdr_ram #(
   parameter int DEPTH  = 512,
   parameter int WIDTH  = 13,
   parameter int ADDR_W = 9
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write the entry, register the read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/ffla_fit_unit.sv
// ffla_fit_unit: compare and subtract unit shared by every step of the free-list walk.
// Decides fit and split for one header and forms the remainder block.
// Depends on ffla_pkg.
module ffla_fit_unit #(
   parameter int HEADER_BYTES = 16,
   parameter int ALIGN_BYTES  = 8,
   parameter int OFF_W        = 13,
   parameter int SZ_W         = 12,
   parameter int WORK_W       = 14
) (
   input  logic [SZ_W-1:0]       hdr_size,
   input  logic [WORK_W-1:0]     need,
   input  logic [OFF_W-1:0]      cur,
   output ffla_pkg::fit_flags_type flags,
   output logic [SZ_W-1:0]       remain,
   output logic [OFF_W-1:0]      split_off
);

   localparam int HBITS = OFF_W - 1;
   localparam int SUM_W = ((OFF_W > WORK_W) ? OFF_W : WORK_W) + 1;
   localparam logic [WORK_W-1:0] SPLIT_MARGIN = WORK_W'(HEADER_BYTES + ALIGN_BYTES);

   logic [WORK_W-1:0] size_ext;
   logic [SUM_W-1:0]  split_sum;

   // Compare the stored size against the need and the split threshold
   always_comb begin
      size_ext    = WORK_W'(hdr_size);
      flags.fits  = size_ext >= need;
      flags.split = size_ext >= (need + SPLIT_MARGIN);
      remain      = SZ_W'(size_ext - need);
      split_sum   = SUM_W'(cur) + SUM_W'(need);
      // Remainder block offset wraps at the heap end
      split_off   = {1'b0, split_sum[HBITS-1:0]};
   end

endmodule

FILE: sv/first_fit_free_list_allocator.sv
// first_fit_free_list_allocator: top level with sequencer, heap size register and
// header stores. Depends on ffla_pkg, ffla_hdr_ram and ffla_fit_unit.
//
// A request is taken when start is high and busy is low; its single result shows on
// rsp_item for exactly one cycle with rsp_valid and cannot be held off. Free, null free
// and zero-size allocate keep busy low and answer in the next cycle. Allocate walks the
// free list one header per cycle through the registered read port of the header stores:
// busy until the fit is found, and for ST_FIX as well if it is split, answering in the
// cycle after that; a miss walks on to the end-of-list marker or the step limit.
// After reset and after every heap_size write, ST_INIT writes the initial header, with
// no clearing pass over the stores. HEAP_BYTES and ALIGN_BYTES must be powers of two.
module first_fit_free_list_allocator #(
   parameter int HEAP_BYTES   = ffla_pkg::HEAP_BYTES_DEF,
   parameter int ALIGN_BYTES  = ffla_pkg::ALIGN_BYTES_DEF,
   parameter int HEADER_BYTES = ffla_pkg::HEADER_BYTES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  ffla_pkg::req_type         req_item,
   output logic                      rsp_valid,
   output ffla_pkg::rsp_type         rsp_item,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [ffla_pkg::CSR_W-1:0] csr_data
);

   localparam int HBITS    = $clog2(HEAP_BYTES);
   localparam int ALIGN_LG = $clog2(ALIGN_BYTES);
   localparam int SLOTS    = HEAP_BYTES / ALIGN_BYTES;
   localparam int SLOT_W   = $clog2(SLOTS);
   localparam int OFF_W    = HBITS + 1;
   localparam int SZ_W     = (HBITS > ffla_pkg::CSR_W) ? HBITS : ffla_pkg::CSR_W;
   localparam int WORK_W   = ((SZ_W > 13) ? SZ_W : 13) + 1;
   localparam int STEP_W   = SLOT_W + 1;
   localparam int ALN_W    = ffla_pkg::SIZE_W + 1;
   localparam int AW       = ((OFF_W + 1) > ffla_pkg::ADDR_W) ? (OFF_W + 1) : ffla_pkg::ADDR_W;
   localparam int FW       = ((HBITS > ffla_pkg::ADDR_W) ? HBITS : ffla_pkg::ADDR_W) + 1;
   localparam logic [OFF_W-1:0]  NO_BLOCK  = OFF_W'(HEAP_BYTES);
   localparam logic [SZ_W-1:0]   MAX_DATA  = SZ_W'(HEAP_BYTES - HEADER_BYTES);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SLOTS - 1);

   function automatic logic [SLOT_W-1:0] slot_of(input logic [OFF_W-1:0] off);
      return off[ALIGN_LG +: SLOT_W];
   endfunction

   // Registers
   ffla_pkg::state_type state_ff, state_in;
   logic [SZ_W-1:0]     heap_size_ff, heap_size_in;
   logic [OFF_W-1:0]    head_ff, head_in;
   logic [OFF_W-1:0]    cur_ff, cur_in;
   logic [OFF_W-1:0]    prev_ff, prev_in;
   logic                have_prev_ff, have_prev_in;
   logic [STEP_W-1:0]   steps_ff, steps_in;
   logic [ALN_W-1:0]    aligned_ff, aligned_in;
   logic [WORK_W-1:0]   need_ff, need_in;
   logic [OFF_W-1:0]    repl_ff, repl_in;
   logic                rsp_valid_ff, rsp_valid_in;
   ffla_pkg::rsp_type   rsp_item_ff, rsp_item_in;

   // Store ports
   logic              size_wr_en, link_wr_en;
   logic [SLOT_W-1:0] size_wr_addr, link_wr_addr, rd_addr;
   logic [SZ_W-1:0]   size_wr_data, size_rd;
   logic [OFF_W-1:0]  link_wr_data, link_rd;

   // Fit unit
   ffla_pkg::fit_flags_type fit;
   logic [SZ_W-1:0]         remain;
   logic [OFF_W-1:0]        split_off;

   // Arithmetic on the accepted item
   logic [ALN_W-1:0]  req_round;
   logic [ALN_W-1:0]  req_aligned;
   logic [FW-1:0]     free_diff;
   logic [OFF_W-1:0]  free_off;
   logic [AW-1:0]     data_off;
   logic [SZ_W-1:0]   csr_ext;
   logic              accept;

   ffla_hdr_ram #(.DEPTH(SLOTS), .WIDTH(SZ_W), .ADDR_W(SLOT_W)) u_size_ram (
      .clock   (clock),
      .wr_en   (size_wr_en),
      .wr_addr (size_wr_addr),
      .wr_data (size_wr_data),
      .rd_addr (rd_addr),
      .rd_data (size_rd)
   );

   ffla_hdr_ram #(.DEPTH(SLOTS), .WIDTH(OFF_W), .ADDR_W(SLOT_W)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_wr_en),
      .wr_addr (link_wr_addr),
      .wr_data (link_wr_data),
      .rd_addr (rd_addr),
      .rd_data (link_rd)
   );

   ffla_fit_unit #(
      .HEADER_BYTES (HEADER_BYTES),
      .ALIGN_BYTES  (ALIGN_BYTES),
      .OFF_W        (OFF_W),
      .SZ_W         (SZ_W),
      .WORK_W       (WORK_W)
   ) u_fit (
      .hdr_size   (size_rd),
      .need       (need_ff),
      .cur        (cur_ff),
      .flags      (fit),
      .remain     (remain),
      .split_off  (split_off)
   );

   // Handshake
   assign busy      = (state_ff != ffla_pkg::ST_IDLE);
   assign csr_ready = (state_ff == ffla_pkg::ST_IDLE) && !start;
   assign accept    = start && !busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // Round the request up, locate a freed header, form the data offset
   always_comb begin
      req_round   = ALN_W'(req_item.request_size) + ALN_W'(ALIGN_BYTES - 1);
      req_aligned = {req_round[ALN_W-1:ALIGN_LG], ALIGN_LG'(0)};
      free_diff   = FW'(req_item.data_address) - FW'(HEADER_BYTES);
      free_off    = {1'b0, free_diff[HBITS-1:ALIGN_LG], ALIGN_LG'(0)};
      data_off    = AW'(cur_ff) + AW'(HEADER_BYTES);
      csr_ext     = SZ_W'(csr_data);
   end

   // Sequencer: next state, store writes and result
   always_comb begin
      state_in     = state_ff;
      heap_size_in = heap_size_ff;
      head_in      = head_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      have_prev_in = have_prev_ff;
      steps_in     = steps_ff;
      aligned_in   = aligned_ff;
      need_in      = need_ff;
      repl_in      = repl_ff;
      rsp_valid_in = 1'b0;
      rsp_item_in  = '{alloc_address: '0, status: ffla_pkg::STAT_ALLOCATED};
      size_wr_en   = 1'b0;
      size_wr_addr = slot_of(cur_ff);
      size_wr_data = SZ_W'(aligned_ff);
      link_wr_en   = 1'b0;
      link_wr_addr = slot_of(prev_ff);
      link_wr_data = repl_ff;
      rd_addr      = slot_of(head_ff);

      unique case (state_ff)
         ffla_pkg::ST_INIT: begin
            // Write the single free block header
            size_wr_en   = 1'b1;
            size_wr_addr = '0;
            size_wr_data = heap_size_ff;
            link_wr_en   = 1'b1;
            link_wr_addr = '0;
            link_wr_data = NO_BLOCK;
            head_in      = '0;
            state_in     = ffla_pkg::ST_IDLE;
         end
         ffla_pkg::ST_IDLE: begin
            priority if (csr_valid && csr_ready) begin
               // Clamp and re-initialise the heap
               heap_size_in = (csr_ext > MAX_DATA) ? MAX_DATA : csr_ext;
               head_in      = '0;
               state_in     = ffla_pkg::ST_INIT;
            end else if (accept) begin
               if (req_item.func == ffla_pkg::FUNC_ALLOC) begin
                  priority if (req_item.request_size == '0) begin
                     rsp_valid_in       = 1'b1;
                     rsp_item_in.status = ffla_pkg::STAT_SIZE_ZERO;
                  end else if (head_ff == NO_BLOCK) begin
                     rsp_valid_in       = 1'b1;
                     rsp_item_in.status = ffla_pkg::STAT_NO_FIT;
                  end else begin
                     // Start the walk at the head; its header read is issued now
                     aligned_in   = req_aligned;
                     need_in      = WORK_W'(req_aligned) + WORK_W'(HEADER_BYTES);
                     cur_in       = head_ff;
                     have_prev_in = 1'b0;
                     steps_in     = '0;
                     state_in     = ffla_pkg::ST_WALK;
                  end
               end else if (req_item.data_address == '0) begin
                  rsp_valid_in       = 1'b1;
                  rsp_item_in.status = ffla_pkg::STAT_NULL_FREE;
               end else begin
                  // Push the block at the head of the list
                  link_wr_en         = 1'b1;
                  link_wr_addr       = slot_of(free_off);
                  link_wr_data       = head_ff;
                  head_in            = free_off;
                  rsp_valid_in       = 1'b1;
                  rsp_item_in.status = ffla_pkg::STAT_FREED;
               end
            end else begin
               // Hold in idle
               state_in = ffla_pkg::ST_IDLE;
            end
         end
         ffla_pkg::ST_WALK: begin
            if (fit.fits) begin
               if (fit.split) begin
                  // Write the remainder header; fix the list next cycle
                  size_wr_en   = 1'b1;
                  size_wr_addr = slot_of(split_off);
                  size_wr_data = remain;
                  link_wr_en   = 1'b1;
                  link_wr_addr = slot_of(split_off);
                  link_wr_data = link_rd;
                  repl_in      = split_off;
                  state_in     = ffla_pkg::ST_FIX;
               end else begin
                  // Unlink the whole block
                  if (have_prev_ff) begin
                     link_wr_en   = 1'b1;
                     link_wr_addr = slot_of(prev_ff);
                     link_wr_data = link_rd;
                  end else begin
                     head_in = link_rd;
                  end
                  rsp_valid_in              = 1'b1;
                  rsp_item_in.alloc_address = data_off[ffla_pkg::ADDR_W-1:0];
                  state_in                  = ffla_pkg::ST_IDLE;
               end
            end else begin
               // Advance to the next free block
               prev_in      = cur_ff;
               have_prev_in = 1'b1;
               cur_in       = link_rd;
               steps_in     = steps_ff + STEP_W'(1);
               rd_addr      = slot_of(link_rd);
               if (link_rd == NO_BLOCK || steps_ff == LAST_STEP) begin
                  rsp_valid_in       = 1'b1;
                  rsp_item_in.status = ffla_pkg::STAT_NO_FIT;
                  state_in           = ffla_pkg::ST_IDLE;
               end
            end
         end
         ffla_pkg::ST_FIX: begin
            // Shrink the block and splice the remainder into its place
            size_wr_en = 1'b1;
            if (have_prev_ff) begin
               link_wr_en = 1'b1;
            end else begin
               head_in = repl_ff;
            end
            rsp_valid_in              = 1'b1;
            rsp_item_in.alloc_address = data_off[ffla_pkg::ADDR_W-1:0];
            state_in                  = ffla_pkg::ST_IDLE;
         end
         default: begin
            state_in = ffla_pkg::ST_INIT;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffla_pkg::ST_INIT;
         heap_size_ff <= SZ_W'(ffla_pkg::INIT_HEAP_SIZE);
         head_ff      <= '0;
         have_prev_ff <= 1'b0;
         steps_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         heap_size_ff <= heap_size_in;
         head_ff      <= head_in;
         have_prev_ff <= have_prev_in;
         steps_ff     <= steps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Walk payload and result
   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      aligned_ff  <= aligned_in;
      need_ff     <= need_in;
      repl_ff     <= repl_in;
      rsp_item_ff <= rsp_item_in;
   end

   // A walk never looks at the end-of-list marker
   a_walk_cur_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == ffla_pkg::ST_WALK |-> cur_ff != NO_BLOCK)
      else $error("walk on end-of-list marker");

   // Every accepted item either occupies the block or answers at once
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy || rsp_valid)
      else $error("accepted item dropped");

   // A successful allocation only comes out of the walk
   a_alloc_from_walk: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status == ffla_pkg::STAT_ALLOCATED |->
         $past(state_ff == ffla_pkg::ST_WALK) || $past(state_ff == ffla_pkg::ST_FIX))
      else $error("allocation reported without a walk");

   // No result while a walk is still in progress
   a_no_rsp_mid_walk: assert property (@(posedge clock) disable iff (reset)
      state_ff == ffla_pkg::ST_WALK && $past(state_ff == ffla_pkg::ST_WALK) |-> !rsp_valid)
      else $error("result during walk");

endmodule
